// ===== sv/ftrm_pkg.sv =====
// Package for the flow table range match block: shared types, codes and defaults.
package ftrm_pkg;

  // Default table size and the port number that means local delivery.
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_LOCAL_PORT  = 3;

  // Field widths fixed by the item format.
  localparam int ADDR_W = 10;
  localparam int HITS_W = 32;

  // Configuration register indexes.
  localparam logic CFG_OWN_LOW  = 1'b0;
  localparam logic CFG_OWN_HIGH = 1'b1;

  // Actions of an added rule.
  localparam logic [1:0] ACT_DROP    = 2'd0;
  localparam logic [1:0] ACT_FORWARD = 2'd1;

  // Port number that stands for the controller.
  localparam logic [1:0] PORT_CTRL = 2'd0;

  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_DROPPED   = 3'd0,
    OUT_FORWARDED = 3'd1,
    OUT_LOCAL     = 3'd2,
    OUT_QUERY     = 3'd3,
    OUT_ADDED     = 3'd4,
    OUT_REJECTED  = 3'd5,
    OUT_ENTRY     = 3'd6
  } outcome_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] packet_address;
    logic [ADDR_W-1:0] new_low;
    logic [ADDR_W-1:0] new_high;
    logic [1:0]        rule_action;
    logic [1:0]        new_port;
    logic [3:0]        read_index;
  } request_t;

  typedef struct packed {
    outcome_t          outcome;
    logic [ADDR_W-1:0] out_address;
    logic [1:0]        out_port;
    logic              entry_valid;
    logic [ADDR_W-1:0] entry_low;
    logic [ADDR_W-1:0] entry_high;
    logic              entry_forwards;
    logic [1:0]        entry_port;
    logic [HITS_W-1:0] entry_hits;
  } result_t;

  // One stored rule.
  typedef struct packed {
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] high;
    logic              forwards;
    logic [1:0]        port;
    logic [HITS_W-1:0] hits;
  } entry_t;

  // Kind of result the datapath builds.
  typedef enum logic [2:0] {
    EM_NONE,
    EM_LOCAL,
    EM_MATCH,
    EM_MISS,
    EM_ADD,
    EM_REJECT,
    EM_READ_REG,
    EM_READ_MEM
  } emit_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_COMPARE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  latch;
    logic  idx_load;
    logic  idx_inc;
    logic  rd_en;
    logic  rd_read;
    logic  hit0_inc;
    logic  add_wr;
    logic  hit_wr;
    emit_t emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       hit0;
    logic       has_rules;
    logic       add_ok;
    logic       read_mem;
    logic       match;
    logic       last;
  } dp_stat_t;

endpackage

// ===== sv/ftrm_ctrl.sv =====
// Controller state machine that sequences decode, table scan and result transfer.
module ftrm_ctrl import ftrm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.command)
          CMD_PACKET: begin
            if (!stat.hit0 && stat.has_rules) state_next = S_FETCH;
            else state_next = S_IDLE;
          end
          CMD_READ: begin
            if (stat.read_mem) state_next = S_FETCH;
            else state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FETCH: state_next = S_COMPARE;
      S_COMPARE: begin
        if (stat.command == CMD_PACKET && !stat.match && !stat.last) state_next = S_FETCH;
        else state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd  = '0;
    cmd.emit = EM_NONE;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.latch = start;
      end
      S_DECODE: begin
        unique case (stat.command)
          CMD_PACKET: begin
            if (stat.hit0) begin
              cmd.hit0_inc = 1'b1;
              cmd.emit     = EM_LOCAL;
            end else if (stat.has_rules) begin
              cmd.idx_load = 1'b1;
            end else begin
              cmd.emit = EM_MISS;
            end
          end
          CMD_ADD: begin
            if (stat.add_ok) begin
              cmd.add_wr = 1'b1;
              cmd.emit   = EM_ADD;
            end else begin
              cmd.emit = EM_REJECT;
            end
          end
          CMD_READ: begin
            if (!stat.read_mem) cmd.emit = EM_READ_REG;
          end
          default: cmd.emit = EM_REJECT;
        endcase
      end
      S_FETCH: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_read = (stat.command == CMD_READ);
      end
      S_COMPARE: begin
        if (stat.command == CMD_READ) begin
          cmd.emit = EM_READ_MEM;
        end else if (stat.match) begin
          cmd.hit_wr = 1'b1;
          cmd.emit   = EM_MATCH;
        end else if (!stat.last) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.emit = EM_MISS;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/ftrm_dp.sv =====
// Datapath: configuration, fixed entry, rule memory, range compare and result register.
module ftrm_dp import ftrm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int LOCAL_PORT  = DEF_LOCAL_PORT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  request_t          request,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output result_t           result,
  output logic              done
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [1:0] LOCAL = 2'(LOCAL_PORT);

  logic [ADDR_W-1:0] own_low;
  logic [ADDR_W-1:0] own_high;
  logic [HITS_W-1:0] hits0;
  logic [CW-1:0]     used;
  logic [IW-1:0]     idx;
  request_t          req;
  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data;
  entry_t            wr_data;
  logic [IW-1:0]     wr_addr;
  logic              wr_en;
  logic [IW-1:0]     rd_addr;
  logic [IW+3:0]     ridx_wide;
  logic [IW-1:0]     ridx;
  logic              ridx_ok;
  logic [HITS_W-1:0] rd_hits_inc;
  result_t           result_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_low  <= '0;
      own_high <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_OWN_LOW) own_low <= cfg_data;
      else own_high <= cfg_data;
    end
  end

  // Request latch, taken on the input transfer.
  always_ff @(posedge clk) begin
    if (cmd.latch) req <= request;
  end

  // Fixed entry hit counter and rule count.
  always_ff @(posedge clk) begin
    if (rst) begin
      hits0 <= '0;
      used  <= CW'(1);
    end else begin
      if (cmd.hit0_inc && hits0 != '1) hits0 <= hits0 + HITS_W'(1);
      if (cmd.add_wr) used <= used + CW'(1);
    end
  end

  // Scan index.
  always_ff @(posedge clk) begin
    if (cmd.idx_load) idx <= IW'(1);
    else if (cmd.idx_inc) idx <= idx + IW'(1);
  end

  // Read index resized to the table index width.
  assign ridx_wide = {{IW{1'b0}}, req.read_index};
  assign ridx      = ridx_wide[IW-1:0];
  assign ridx_ok   = ({{CW{1'b0}}, req.read_index} < {4'b0000, used});

  // Rule memory: one write port, one registered read port.
  assign rd_addr     = cmd.rd_read ? ridx : idx;
  assign rd_hits_inc = (rd_data.hits == '1) ? rd_data.hits : rd_data.hits + HITS_W'(1);

  always_comb begin
    wr_en   = cmd.add_wr || cmd.hit_wr;
    wr_addr = idx;
    wr_data = rd_data;
    wr_data.hits = rd_hits_inc;
    if (cmd.add_wr) begin
      wr_addr          = used[IW-1:0];
      wr_data.low      = req.new_low;
      wr_data.high     = req.new_high;
      wr_data.forwards = (req.rule_action == ACT_FORWARD);
      wr_data.port     = (req.rule_action == ACT_FORWARD) ? req.new_port : 2'b00;
      wr_data.hits     = HITS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  // Status toward the controller.
  always_comb begin
    stat.command   = req.command;
    stat.hit0      = (req.packet_address >= own_low) && (req.packet_address <= own_high);
    stat.has_rules = (used > CW'(1));
    stat.add_ok    = (req.rule_action == ACT_DROP ||
                      (req.rule_action == ACT_FORWARD && req.new_port != PORT_CTRL)) &&
                     (used < CW'(TABLE_DEPTH));
    stat.read_mem  = ridx_ok && (req.read_index != 4'd0);
    stat.match     = (req.packet_address >= rd_data.low) &&
                     (req.packet_address <= rd_data.high);
    stat.last      = ((CW'(idx) + CW'(1)) >= used);
  end

  // Result assembly.
  always_comb begin
    result_next = '0;
    result_next.outcome = OUT_REJECTED;
    case (cmd.emit)
      EM_LOCAL: result_next.outcome = OUT_LOCAL;
      EM_MATCH: begin
        if (!rd_data.forwards) begin
          result_next.outcome = OUT_DROPPED;
        end else if (rd_data.port == LOCAL) begin
          result_next.outcome = OUT_LOCAL;
        end else begin
          result_next.outcome     = OUT_FORWARDED;
          result_next.out_address = req.packet_address;
          result_next.out_port    = rd_data.port;
        end
      end
      EM_MISS: begin
        result_next.outcome     = OUT_QUERY;
        result_next.out_address = req.packet_address;
      end
      EM_ADD: begin
        result_next.outcome = OUT_ADDED;
        if (req.rule_action == ACT_FORWARD) begin
          result_next.out_address = req.new_low;
          result_next.out_port    = req.new_port;
        end
      end
      EM_READ_REG: begin
        result_next.outcome = OUT_ENTRY;
        if (ridx_ok) begin
          result_next.entry_valid    = 1'b1;
          result_next.entry_low      = own_low;
          result_next.entry_high     = own_high;
          result_next.entry_forwards = 1'b1;
          result_next.entry_port     = LOCAL;
          result_next.entry_hits     = hits0;
        end
      end
      EM_READ_MEM: begin
        result_next.outcome        = OUT_ENTRY;
        result_next.entry_valid    = 1'b1;
        result_next.entry_low      = rd_data.low;
        result_next.entry_high     = rd_data.high;
        result_next.entry_forwards = rd_data.forwards;
        result_next.entry_port     = rd_data.port;
        result_next.entry_hits     = rd_data.hits;
      end
      default: result_next.outcome = OUT_REJECTED;
    endcase
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) result <= result_next;
  end

endmodule

// ===== sv/flow_table_range_match.sv =====
// Top level of the flow table with first-match destination range lookup.
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ---------------------------------
//  request   start high, busy low    request (request_t)
//  result    done, one cycle         result (result_t)
//  config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
// An add, a rejected command, a read of the fixed entry or of a missing entry,
// and a packet that hits the fixed entry are answered from the decode state.
// A packet scans the stored rules one at a time through the single read port
// of the rule memory, with a fetch and a compare state per rule. A read of a
// stored rule also fetches it. A new request may transfer in the cycle its
// predecessor's result is on the ports. Reset is synchronous and leaves only
// the fixed entry in the table; the result side never stalls.
module flow_table_range_match import ftrm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int LOCAL_PORT  = DEF_LOCAL_PORT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  request_t          request,
  output logic              done,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  ftrm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ftrm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .LOCAL_PORT  (LOCAL_PORT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

  // A result is only presented once the controller has returned to idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while controller busy");

  // A request transfer makes the block busy and gives no result in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy && !done))
    else $error("request transfer not followed by busy");

  // Busy only rises after a request transfer.
  assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule
